>>> hw/rtl/pbm_ascii_stream_parser_core_macros.svh
// assertion macros for the bitmap text parser
// no dependencies; included by the top level
`ifndef PBM_ASCII_STREAM_PARSER_CORE_MACROS_SVH
`define PBM_ASCII_STREAM_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PBM_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pbm parser check failed");

// next-cycle implication, checked out of reset
`define PBM_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pbm parser check failed");

`endif

>>> hw/rtl/pbm_pkg.sv
// types and constants of the bitmap text parser
// no dependencies; used by pbm_ascii_stream_parser_core
`timescale 1ns / 1ps

package pbm_pkg;

    localparam int POS_W  = 12;
    localparam int ERR_W  = 2;
    localparam int EVT_W  = 2;
    localparam int DATA_W = 56;

    // parser phases
    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_WANT_ONE   = 4'd1,
        PH_WANT_THIRD = 4'd2,
        PH_SKIP_MAGIC = 4'd3,
        PH_LINE_START = 4'd4,
        PH_COMMENT    = 4'd5,
        PH_WIDTH      = 4'd6,
        PH_HEIGHT     = 4'd7,
        PH_PIXELS     = 4'd8
    } phase_t;

    // result kinds
    localparam logic [EVT_W-1:0] EV_PIXEL = 2'd0;
    localparam logic [EVT_W-1:0] EV_DIMS  = 2'd1;
    localparam logic [EVT_W-1:0] EV_ERROR = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_MAGIC  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_WIDTH  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_HEIGHT = 2'd2;
    localparam logic [ERR_W-1:0] ERR_LARGE  = 2'd3;

    // characters
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef struct packed {
        logic [EVT_W-1:0] event_res;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             black;
        logic             last_pixel;
        logic [POS_W-1:0] width_out;
        logic [POS_W-1:0] height_out;
        logic [ERR_W-1:0] error_code;
    } res_t;

endpackage

>>> hw/rtl/pbm_ascii_stream_parser_core.sv
// streaming parser for ASCII bitmap (P1) text, one character per beat
// depends on pbm_pkg and pbm_ascii_stream_parser_core_macros.svh
`timescale 1ns / 1ps

// One character of the file enters on each s_ beat, with s_tuser set on the first
// character of a file. The parser checks the "P1" magic line, skips comment lines
// that follow it, reads decimal width and height, then gives one pixel beat per
// '0' or '1' character with its 1-based column and row; the final pixel carries
// m_tlast. A dimensions beat is given on the character that ends the height, and
// an error beat on bad magic, a malformed number or a dimension above MAX_DIM,
// after which characters are dropped until the next file start. A new character is
// taken every cycle while s_tready is high: the whole per-character decision is one
// pass of logic from the accepted beat into the output register, and each result
// shows on m_ from that register. A two-entry output (output register plus skid
// register) keeps s_tready registered; it drops only while the skid register
// holds a beat that the sink has not yet taken.
`include "pbm_ascii_stream_parser_core_macros.svh"

module pbm_ascii_stream_parser_core #(
    parameter int MAX_DIM = 4095
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] data_byte
    input  logic [0:0]               s_tuser,   // [0] file_start
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [pbm_pkg::DATA_W-1:0] m_tdata, // [11:0] pos_x, [23:12] pos_y,
                                                // [24] black, [36:25] width_out,
                                                // [48:37] height_out,
                                                // [50:49] error_code, rest zero
    output logic [pbm_pkg::EVT_W-1:0]  m_tuser, // [1:0] event_res
    output logic                     m_tlast    // last_pixel
);
    import pbm_pkg::*;

    // dimension values up to MAX_DIM; a digit step can reach MAX_DIM*10+9
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = $clog2(MAX_DIM * 10 + 10);

    // parser state
    phase_t             phase_reg, phase_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [DIM_W-1:0]   acc_reg, acc_next;
    logic               seen_reg, seen_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;

    // output register and skid register
    logic               out_valid_reg;
    res_t               out_data_reg;
    logic               skid_valid_reg;
    res_t               skid_data_reg;

    // per-character decode
    logic               in_fire;
    logic               out_pop;
    logic [7:0]         chr;
    logic               is_digit;
    logic               is_space;
    logic [ACC_W-1:0]   acc_sum;
    logic               acc_big;
    logic               last_px;
    logic               res_valid;
    logic [EVT_W-1:0]   res_event;
    logic [ERR_W-1:0]   res_err;
    logic               res_black;
    logic               res_last;
    logic               res_pos;
    res_t               res_data;

    assign s_tready = ~skid_valid_reg;
    assign in_fire  = s_tvalid & s_tready;
    assign out_pop  = out_valid_reg & m_tready;

    assign chr      = s_tdata;
    assign is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
    assign is_space = chr inside {8'h20, [8'h09:8'h0D]};
    // acc*10 + digit, done as shifts and adds
    assign acc_sum  = (ACC_W'(acc_reg) << 3) + (ACC_W'(acc_reg) << 1) + ACC_W'(chr[3:0]);
    assign acc_big  = acc_sum > ACC_W'(MAX_DIM);
    assign last_px  = (col_reg == width_reg) && (row_reg == height_reg);

    // next state and result for the accepted character
    always_comb begin
        phase_next  = phase_reg;
        width_next  = width_reg;
        height_next = height_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        res_valid   = 1'b0;
        res_event   = EV_PIXEL;
        res_err     = ERR_MAGIC;
        res_black   = 1'b0;
        res_last    = 1'b0;
        res_pos     = 1'b0;

        if (s_tuser[0]) begin
            // new file: clear everything, first character must be 'P'
            width_next  = '0;
            height_next = '0;
            acc_next    = '0;
            seen_next   = 1'b0;
            col_next    = DIM_W'(1);
            row_next    = DIM_W'(1);
            if (chr != CH_P) begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                res_event  = EV_ERROR;
                res_err    = ERR_MAGIC;
            end else begin
                phase_next = PH_WANT_ONE;
            end
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_WANT_ONE: begin
                    if (chr != CH_ONE) begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_event  = EV_ERROR;
                        res_err    = ERR_MAGIC;
                    end else begin
                        phase_next = PH_WANT_THIRD;
                    end
                end
                PH_WANT_THIRD: begin
                    phase_next = (chr == CH_LF) ? PH_LINE_START : PH_SKIP_MAGIC;
                end
                PH_SKIP_MAGIC, PH_COMMENT: begin
                    if (chr == CH_LF) begin
                        phase_next = PH_LINE_START;
                    end
                end
                PH_LINE_START, PH_WIDTH: begin
                    if (phase_reg == PH_LINE_START && chr == CH_HASH) begin
                        phase_next = PH_COMMENT;
                    end else if (is_digit) begin
                        acc_next   = DIM_W'(acc_sum);
                        seen_next  = 1'b1;
                        phase_next = PH_WIDTH;
                        if (acc_big) begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_ERROR;
                            res_err    = ERR_LARGE;
                        end
                    end else if (!seen_reg) begin
                        if (is_space) begin
                            phase_next = PH_WIDTH;
                        end else begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_ERROR;
                            res_err    = ERR_WIDTH;
                        end
                    end else begin
                        // width ends; the same non-digit opens the height
                        width_next = acc_reg;
                        acc_next   = '0;
                        seen_next  = 1'b0;
                        if (is_space) begin
                            phase_next = PH_HEIGHT;
                        end else begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_ERROR;
                            res_err    = ERR_HEIGHT;
                        end
                    end
                end
                PH_HEIGHT: begin
                    if (is_digit) begin
                        acc_next  = DIM_W'(acc_sum);
                        seen_next = 1'b1;
                        if (acc_big) begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_ERROR;
                            res_err    = ERR_LARGE;
                        end
                    end else if (!seen_reg) begin
                        if (!is_space) begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res_event  = EV_ERROR;
                            res_err    = ERR_HEIGHT;
                        end
                    end else begin
                        height_next = acc_reg;
                        acc_next    = '0;
                        seen_next   = 1'b0;
                        col_next    = DIM_W'(1);
                        row_next    = DIM_W'(1);
                        res_valid   = 1'b1;
                        res_event   = EV_DIMS;
                        // zero-sized image has no pixels
                        phase_next  = (width_reg == '0 || acc_reg == '0) ? PH_IDLE
                                                                        : PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    if (chr == CH_ZERO || chr == CH_ONE) begin
                        res_valid = 1'b1;
                        res_event = EV_PIXEL;
                        res_pos   = 1'b1;
                        res_black = (chr == CH_ONE);
                        res_last  = last_px;
                        if (last_px) begin
                            phase_next = PH_IDLE;
                        end else if (col_reg == width_reg) begin
                            col_next = DIM_W'(1);
                            row_next = row_reg + DIM_W'(1);
                        end else begin
                            col_next = col_reg + DIM_W'(1);
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // dimensions shown are those after this character
        res_data.event_res  = res_event;
        res_data.pos_x      = res_pos ? POS_W'(col_reg) : '0;
        res_data.pos_y      = res_pos ? POS_W'(row_reg) : '0;
        res_data.black      = res_black;
        res_data.last_pixel = res_last;
        res_data.width_out  = POS_W'(width_next);
        res_data.height_out = POS_W'(height_next);
        res_data.error_code = (res_event == EV_ERROR) ? res_err : ERR_MAGIC;
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            width_reg  <= '0;
            height_reg <= '0;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            col_reg    <= DIM_W'(1);
            row_reg    <= DIM_W'(1);
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // output register with skid: a result lands in the skid register only when
    // the output register is full and not being drained this cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire && res_valid) begin
            if (!out_valid_reg || out_pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_fire && res_valid) begin
            if (!out_valid_reg || out_pop) begin
                out_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end
    end

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.event_res;
    assign m_tlast  = out_data_reg.last_pixel;
    assign m_tdata  = {5'd0,
                       out_data_reg.error_code,
                       out_data_reg.height_out,
                       out_data_reg.width_out,
                       out_data_reg.black,
                       out_data_reg.pos_y,
                       out_data_reg.pos_x};

    // a held skid beat always sits behind a full output register
    `PBM_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    // no result kind beyond pixel, dimensions and error
    `PBM_ASSERT_NOW(a_event_legal, aclk, aresetn, m_tvalid, m_tuser == EV_PIXEL || m_tuser == EV_DIMS || m_tuser == EV_ERROR)
    // pixel phase only with a non-empty image and column and row inside it
    `PBM_ASSERT_NOW(a_pixel_dims, aclk, aresetn, phase_reg == PH_PIXELS,
        width_reg != '0 && height_reg != '0 && col_reg <= width_reg &&
        row_reg <= height_reg)
    // a beat stalled by the sink is still there next cycle
    `PBM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule

>>> verif/tb_pbm_ascii_stream_parser_core.sv
// self-checking testbench for pbm_ascii_stream_parser_core: directed rows, then random files
// checked beat by beat against an in-bench parser model; needs pbm_pkg and the core rtl
`timescale 1ns / 1ps

module tb_pbm_ascii_stream_parser_core;
    import pbm_pkg::*;

    localparam int MAX_SIZE     = 4095;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LOW_X = 8'h78;

    typedef enum int {NUM_MORE, NUM_DONE, NUM_FAIL} num_step_t;
    typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_SIGN, FLAW_HASH, FLAW_CUT, FLAW_NOISE} flaw_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

    // one character beat; typed rows carry their own expected result
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        res_t       want;
    } char_beat_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [DATA_W-1:0]   m_tdata;
    logic [EVT_W-1:0]    m_tuser;
    logic                m_tlast;

    pbm_ascii_stream_parser_core #(
        .MAX_DIM (MAX_SIZE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // parser model state
    phase_t      ph = PH_IDLE;
    logic [11:0] wd_reg = '0;
    logic [11:0] ht_reg = '0;
    int          acc = 0;
    bit          seen = 1'b0;
    int          col = 1;
    int          row = 1;

    char_beat_t  beat_q [$];
    res_t        result_q [$];
    char_beat_t  cur;
    char_beat_t  dir_rows [25];

    int cycle_cnt = 0;
    int live_items = 0;
    int fails = 0;
    int n_files = 0;
    int n_pix = 0;
    int n_dims = 0;
    int n_err = 0;
    int burst_left = 0;
    bit hold_on = 1'b0;

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic res_t make_res(logic [EVT_W-1:0] ev, int x, int y, bit blk, bit last,
                                      logic [ERR_W-1:0] err);
        res_t r;
        r.event_res  = ev;
        r.pos_x      = x[11:0];
        r.pos_y      = y[11:0];
        r.black      = blk;
        r.last_pixel = last;
        r.width_out  = wd_reg;
        r.height_out = ht_reg;
        r.error_code = err;
        return r;
    endfunction

    function automatic bit raise(logic [ERR_W-1:0] code, output res_t r);
        ph = PH_IDLE;
        r = make_res(EV_ERROR, 0, 0, 1'b0, 1'b0, code);
        return 1'b1;
    endfunction

    function automatic num_step_t scan_digit(logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = acc * 10 + int'(b - CH_ZERO);
            seen = 1'b1;
            return NUM_MORE;
        end
        if (!seen)
            return is_blank(b) ? NUM_MORE : NUM_FAIL;
        return NUM_DONE;
    endfunction

    // advances the model by one character; returns 1 when a result beat is due
    function automatic bit parse_char(logic [7:0] b, logic start, output res_t r);
        num_step_t st;
        bit last;
        r = '0;
        if (start) begin
            wd_reg = '0;
            ht_reg = '0;
            acc = 0;
            seen = 1'b0;
            col = 1;
            row = 1;
            if (b != CH_P)
                return raise(ERR_MAGIC, r);
            ph = PH_WANT_ONE;
            return 1'b0;
        end
        case (ph)
            PH_WANT_ONE: begin
                if (b != CH_ONE)
                    return raise(ERR_MAGIC, r);
                ph = PH_WANT_THIRD;
                return 1'b0;
            end
            PH_WANT_THIRD: begin
                ph = (b == CH_LF) ? PH_LINE_START : PH_SKIP_MAGIC;
                return 1'b0;
            end
            PH_SKIP_MAGIC, PH_COMMENT: begin
                if (b == CH_LF)
                    ph = PH_LINE_START;
                return 1'b0;
            end
            PH_LINE_START, PH_WIDTH, PH_HEIGHT: begin
                if (ph == PH_LINE_START) begin
                    if (b == CH_HASH) begin
                        ph = PH_COMMENT;
                        return 1'b0;
                    end
                    ph = PH_WIDTH;
                end
                if (ph == PH_WIDTH) begin
                    st = scan_digit(b);
                    if (st == NUM_FAIL)
                        return raise(ERR_WIDTH, r);
                    if (st == NUM_MORE) begin
                        if (acc > MAX_SIZE)
                            return raise(ERR_LARGE, r);
                        return 1'b0;
                    end
                    // the byte that ends the width is scanned again as height
                    wd_reg = acc[11:0];
                    acc = 0;
                    seen = 1'b0;
                    ph = PH_HEIGHT;
                end
                st = scan_digit(b);
                if (st == NUM_FAIL)
                    return raise(ERR_HEIGHT, r);
                if (st == NUM_MORE) begin
                    if (acc > MAX_SIZE)
                        return raise(ERR_LARGE, r);
                    return 1'b0;
                end
                ht_reg = acc[11:0];
                acc = 0;
                seen = 1'b0;
                col = 1;
                row = 1;
                ph = (wd_reg == 0 || ht_reg == 0) ? PH_IDLE : PH_PIXELS;
                r = make_res(EV_DIMS, 0, 0, 1'b0, 1'b0, '0);
                return 1'b1;
            end
            PH_PIXELS: begin
                if (b != CH_ZERO && b != CH_ONE)
                    return 1'b0;
                last = (col == wd_reg && row == ht_reg);
                r = make_res(EV_PIXEL, col, row, b == CH_ONE, last, '0);
                if (last) begin
                    ph = PH_IDLE;
                end else begin
                    col++;
                    if (col > wd_reg) begin
                        col = 1;
                        row++;
                    end
                end
                return 1'b1;
            end
            default: begin
                ph = PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // ---- file text generation

    function automatic void put(logic [7:0] b, logic start = 1'b0);
        char_beat_t c;
        c = '0;
        c.data = b;
        c.start = start;
        beat_q.push_back(c);
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] z);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == a || b == z);
        return b;
    endfunction

    function automatic logic [7:0] blank();
        return ($urandom_range(0, 2) == 0) ? CH_TAB + 8'($urandom_range(0, 4)) : CH_SPACE;
    endfunction

    function automatic logic [7:0] sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic void put_number(int n);
        string s;
        s = $sformatf("%0d", n);
        if ($urandom_range(0, 7) == 0)
            put(CH_ZERO);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic int pick_dim();
        int s;
        s = $urandom_range(0, 99);
        if (s < 5)
            return 0;
        if (s < 8)
            return $urandom_range(MAX_SIZE + 1, 99999);
        if (s < 10)
            return MAX_SIZE;
        return $urandom_range(1, 7);
    endfunction

    function automatic void add_file(int w, int h, flaw_t flaw);
        int first;
        int cut;
        int idx;
        first = beat_q.size();
        n_files++;
        if (flaw == FLAW_MAGIC) begin
            if ($urandom_range(0, 1)) begin
                put(any_but(CH_P, CH_P), 1'b1);
            end else begin
                put(CH_P, 1'b1);
                put(any_but(CH_ONE, CH_ONE));
            end
            repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
            return;
        end
        put(CH_P, 1'b1);
        put(CH_ONE);
        repeat ($urandom_range(0, 3)) put(any_but(CH_LF, CH_LF));
        put(CH_LF);
        repeat ($urandom_range(0, 2)) begin
            put(CH_HASH);
            repeat ($urandom_range(0, 4)) put(any_but(CH_LF, CH_LF));
            put(CH_LF);
        end
        repeat ($urandom_range(0, 2)) put(blank());
        if (flaw == FLAW_SIGN && $urandom_range(0, 1))
            put(sign());
        put_number(w);
        // a hash or a sign between the numbers spoils the height
        if (flaw == FLAW_HASH)
            put(CH_HASH);
        else if (flaw == FLAW_SIGN)
            put(sign());
        else
            repeat ($urandom_range(1, 2)) put(blank());
        put_number(h);
        put(blank());
        if (w > 0 && h > 0 && w <= MAX_SIZE && h <= MAX_SIZE) begin
            repeat (w * h) begin
                if ($urandom_range(0, 5) == 0)
                    put($urandom_range(0, 1) ? blank() : any_but(CH_ZERO, CH_ONE));
                put($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
            end
        end
        repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
        if (flaw == FLAW_CUT && beat_q.size() > first + 2) begin
            cut = $urandom_range(first + 1, beat_q.size() - 1);
            while (beat_q.size() > cut)
                void'(beat_q.pop_back());
        end
        if (flaw == FLAW_NOISE) begin
            idx = $urandom_range(first + 1, beat_q.size() - 1);
            beat_q[idx].data = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void add_random_file();
        int w;
        int h;
        int pick;
        flaw_t flaw;
        w = pick_dim();
        h = pick_dim();
        // a full-width dimension is only announced, never filled
        if (w == MAX_SIZE)
            h = 0;
        else if (h == MAX_SIZE)
            w = 0;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            flaw = FLAW_MAGIC;
        else if (pick < 10)
            flaw = FLAW_SIGN;
        else if (pick < 13)
            flaw = FLAW_HASH;
        else if (pick < 18)
            flaw = FLAW_CUT;
        else if (pick < 24)
            flaw = FLAW_NOISE;
        else
            flaw = FLAW_NONE;
        add_file(w, h, flaw);
    endfunction

    // ---- sender: bursts of beats with random gaps, inputs change on the falling edge

    task automatic send_beats();
        char_beat_t c;
        int gap;
        while (beat_q.size() > 0) begin
            if (burst_left == 0 && !hold_on) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 40);
            end
            c = beat_q.pop_front();
            cur = c;
            s_tdata = c.data;
            s_tuser = c.start;
            s_tvalid = 1'b1;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            @(negedge aclk);
            if (burst_left > 0)
                burst_left--;
        end
    endtask

    // ---- receiver: its own stall pattern, plus the long hold-offs below

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(negedge aclk) begin
        rx_tick++;
        if (hold_on) begin
            m_tready = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_COIN:   m_tready = 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready = ($urandom_range(0, 7) != 0);
                default:   m_tready = (rx_tick % 4 == 0);
            endcase
        end
    end

    // long sink hold-offs while the sender keeps offering, to fill the output stage
    initial begin
        wait (live_items >= 600);
        @(negedge aclk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_on = 1'b0;
        wait (live_items >= 1300);
        @(negedge aclk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        hold_on = 1'b0;
    end

    // ---- checking

    task automatic check_beat(res_t got, logic [DATA_W-52:0] pad);
        res_t want;
        if (result_q.size() == 0) begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("unexpected beat: ev=%0d x=%0d y=%0d err=%0d",
                         got.event_res, got.pos_x, got.pos_y, got.error_code);
            return;
        end
        want = result_q.pop_front();
        if (want.event_res == EV_PIXEL)
            n_pix++;
        else if (want.event_res == EV_DIMS)
            n_dims++;
        else
            n_err++;
        if (got.event_res !== want.event_res || got.pos_x !== want.pos_x ||
            got.pos_y !== want.pos_y || got.black !== want.black ||
            got.last_pixel !== want.last_pixel || got.width_out !== want.width_out ||
            got.height_out !== want.height_out || got.error_code !== want.error_code ||
            pad !== '0) begin
            fails++;
            if (fails <= REPORT_MAX) begin
                $display("exp: ev=%0d x=%0d y=%0d blk=%0d last=%0d w=%0d h=%0d err=%0d",
                         want.event_res, want.pos_x, want.pos_y, want.black,
                         want.last_pixel, want.width_out, want.height_out, want.error_code);
                $display("got: ev=%0d x=%0d y=%0d blk=%0d last=%0d w=%0d h=%0d err=%0d pad=%h",
                         got.event_res, got.pos_x, got.pos_y, got.black,
                         got.last_pixel, got.width_out, got.height_out, got.error_code, pad);
            end
        end
    endtask

    always @(posedge aclk) begin
        res_t r;
        res_t act;
        bit   due;
        if (aresetn) begin
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("pbm_ascii_stream_parser_core: mismatch");
                $finish;
            end else begin
                if (s_tvalid && s_tready) begin
                    if (cur.start || ph != PH_IDLE)
                        live_items++;
                    due = parse_char(cur.data, cur.start, r);
                    if (cur.typed) begin
                        r = cur.want;
                        due = 1'b1;
                    end
                    if (due)
                        result_q.push_back(r);
                end
                if (m_tvalid && m_tready) begin
                    act.event_res  = m_tuser;
                    act.pos_x      = m_tdata[11:0];
                    act.pos_y      = m_tdata[23:12];
                    act.black      = m_tdata[24];
                    act.last_pixel = m_tlast;
                    act.width_out  = m_tdata[36:25];
                    act.height_out = m_tdata[48:37];
                    act.error_code = m_tdata[50:49];
                    check_beat(act, m_tdata[DATA_W-1:51]);
                end
            end
        end
    end

    // ---- main sequence

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cur = '0;
        // directed rows: bad magic, comment then sign, oversize width, smallest image
        dir_rows = '{
            '{8'hFF,         1'b1, 1'b1, '{EV_ERROR, 12'd0, 12'd0, 1'b0, 1'b0,
                                           12'd0, 12'd0, ERR_MAGIC}},
            '{CH_P,          1'b1, 1'b0, '0},
            '{CH_ZERO + 8'd2, 1'b0, 1'b1, '{EV_ERROR, 12'd0, 12'd0, 1'b0, 1'b0,
                                            12'd0, 12'd0, ERR_MAGIC}},
            '{CH_P,          1'b1, 1'b0, '0},
            '{CH_ONE,        1'b0, 1'b0, '0},
            '{CH_LF,         1'b0, 1'b0, '0},
            '{CH_HASH,       1'b0, 1'b0, '0},
            '{CH_LF,         1'b0, 1'b0, '0},
            '{CH_MINUS,      1'b0, 1'b1, '{EV_ERROR, 12'd0, 12'd0, 1'b0, 1'b0,
                                           12'd0, 12'd0, ERR_WIDTH}},
            '{CH_P,          1'b1, 1'b0, '0},
            '{CH_ONE,        1'b0, 1'b0, '0},
            '{CH_LOW_X,      1'b0, 1'b0, '0},
            '{CH_LF,         1'b0, 1'b0, '0},
            '{CH_ZERO + 8'd4, 1'b0, 1'b0, '0},
            '{CH_ZERO,       1'b0, 1'b0, '0},
            '{CH_NINE,       1'b0, 1'b0, '0},
            '{CH_ZERO + 8'd6, 1'b0, 1'b1, '{EV_ERROR, 12'd0, 12'd0, 1'b0, 1'b0,
                                            12'd0, 12'd0, ERR_LARGE}},
            '{CH_P,          1'b1, 1'b0, '0},
            '{CH_ONE,        1'b0, 1'b0, '0},
            '{CH_LF,         1'b0, 1'b0, '0},
            '{CH_ONE,        1'b0, 1'b0, '0},
            '{CH_SPACE,      1'b0, 1'b0, '0},
            '{CH_ONE,        1'b0, 1'b0, '0},
            '{CH_LF,         1'b0, 1'b1, '{EV_DIMS, 12'd0, 12'd0, 1'b0, 1'b0,
                                           12'd1, 12'd1, 2'b00}},
            '{CH_ONE,        1'b0, 1'b1, '{EV_PIXEL, 12'd1, 12'd1, 1'b1, 1'b1,
                                           12'd1, 12'd1, 2'b00}}
        };
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < $size(dir_rows); i++)
            beat_q.push_back(dir_rows[i]);
        send_beats();

        while (live_items < ITEM_TARGET) begin
            add_random_file();
            send_beats();
        end
        s_tvalid = 1'b0;

        while (result_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_q.size() > 0) begin
            fails += result_q.size();
            $display("%0d expected beats never arrived", result_q.size());
        end

        $display("ran %0d random files, %0d parsed characters in %0d cycles",
                 n_files, live_items, cycle_cnt);
        $display("checked %0d pixel, %0d dimension and %0d error beats; %0d failures",
                 n_pix, n_dims, n_err, fails);
        if (fails == 0) begin
            $display("pbm_ascii_stream_parser_core: match");
        end else begin
            $display("pbm_ascii_stream_parser_core: mismatch");
        end
        $finish;
    end

endmodule

>>> pbm_ascii_stream_parser_core.f
+incdir+hw/rtl
hw/rtl/pbm_pkg.sv
hw/rtl/pbm_ascii_stream_parser_core.sv
verif/tb_pbm_ascii_stream_parser_core.sv
